/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL modules.
// Both expect i_clk in the module; SSS_ASSERT also i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define SSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every rising edge, reset included.
`define SSS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/sss_pkg.sv */
package sss_pkg;

    // Fixed port widths of the item fields.
    localparam int KEY_W  = 10;
    localparam int POS_W  = 10;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int ECNT_W = 11;

    // Operation carried by an input item.
    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_LOOKUP = 2'd2,
        KIND_READ   = 2'd3
    } t_kind;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_PRESENT = 2'd1;
    localparam logic [STAT_W-1:0] ST_ABSENT  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic accept;
        logic eval;
        logic fetch;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic need_fetch;
        logic out_busy;
    } t_sts;

endpackage

/* rtl/sparse_set_store.sv */
// Sparse set store: keys map to entries packed densely in memory, and each item
// inserts, removes, looks up a key or reads a dense position, giving one result.
// An insert, a remove, a read and a lookup of an absent key pass the evaluate
// and done states before the next item is accepted; a lookup that hits also
// passes a fetch state, since its value address comes from the key map and
// needs a second dependent read of the value memory. The result is held in an
// output register, so the next item is accepted while it waits. After reset the
// valid marks are swept clear, one per cycle, before the first item is accepted.
module sparse_set_store import sss_pkg::*; #(
    parameter int CAPACITY   = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_kind,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [VAL_W-1:0]  i_value,
    input  logic [POS_W-1:0]  i_position,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [STAT_W-1:0] o_status,
    output logic [VAL_W-1:0]  o_found_value,
    output logic [KEY_W-1:0]  o_found_key,
    output logic [POS_W-1:0]  o_found_position,
    output logic [ECNT_W-1:0] o_entry_count
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer for the clearing pass and the steps of each item.
    sss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Memories, count and result registers.
    sss_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_kind           (i_kind),
        .i_key            (i_key),
        .i_value          (i_value),
        .i_position       (i_position),
        .i_ready          (i_ready),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_found_value    (o_found_value),
        .o_found_key      (o_found_key),
        .o_found_position (o_found_position),
        .o_entry_count    (o_entry_count)
    );

endmodule

/* rtl/sss_ram.sv */
module sss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/sss_ctrl.sv */
`include "assert_macros.svh"

module sss_ctrl import sss_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_FETCH,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    // Commands and next state follow from the current state.
    always_comb begin
        cmd     = '0;
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    cmd.accept = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.eval = 1'b1;
                n_state  = i_sts.need_fetch ? S_FETCH : S_DONE;
            end
            S_FETCH: begin
                cmd.fetch = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // State register; reset starts the clearing pass over the valid marks.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_cmd   = cmd;

    // An accepted item is evaluated in the very next cycle.
    `SSS_ASSERT(a_accept_eval, cmd.accept |=> (r_state == S_EVAL), "accept not followed by eval")
    // Reset always restarts the clearing pass.
    `SSS_ASSERT_RST(a_reset_clear, !i_rst_n |=> (r_state == S_CLEAR), "reset did not clear")
    // Only a hit lookup takes the second read.
    `SSS_ASSERT(a_fetch_src, (r_state == S_FETCH) |-> $past(cmd.eval && i_sts.need_fetch),
        "fetch without a lookup hit")

endmodule

/* rtl/sss_dp.sv */
`include "assert_macros.svh"

module sss_dp import sss_pkg::*; #(
    parameter int CAPACITY   = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [1:0]        i_kind,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [VAL_W-1:0]  i_value,
    input  logic [POS_W-1:0]  i_position,
    input  logic              i_ready,
    output logic              o_valid,
    output logic [STAT_W-1:0] o_status,
    output logic [VAL_W-1:0]  o_found_value,
    output logic [KEY_W-1:0]  o_found_key,
    output logic [POS_W-1:0]  o_found_position,
    output logic [ECNT_W-1:0] o_entry_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // Latched item.
    t_kind                 r_kind;
    logic [KEY_W-1:0]      r_key;
    logic [DATA_WIDTH-1:0] r_value;
    logic [POS_W-1:0]      r_pos;

    // Store control.
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [AW-1:0]         r_clr_addr;

    // Result waiting for the output register, and the output register itself.
    logic [STAT_W-1:0]     r_res_status;
    logic [VAL_W-1:0]      r_res_value;
    logic [KEY_W-1:0]      r_res_key;
    logic [POS_W-1:0]      r_res_pos;
    logic [ECNT_W-1:0]     r_res_count;
    logic [STAT_W-1:0]     n_res_status;
    logic [VAL_W-1:0]      n_res_value;
    logic [KEY_W-1:0]      n_res_key;
    logic [POS_W-1:0]      n_res_pos;
    logic                  r_out_valid;
    logic [STAT_W-1:0]     r_out_status;
    logic [VAL_W-1:0]      r_out_value;
    logic [KEY_W-1:0]      r_out_key;
    logic [POS_W-1:0]      r_out_pos;
    logic [ECNT_W-1:0]     r_out_count;

    // Memory read data.
    logic [0:0]            valid_rd;
    logic [AW-1:0]         map_rd;
    logic [AW-1:0]         keys_rd;
    logic [DATA_WIDTH-1:0] vals_rd;

    // Decisions in the evaluation cycle.
    logic                  in_range;
    logic                  present;
    logic                  full;
    logic                  insert_ok;
    logic                  remove_ok;
    logic                  need_fetch;
    logic                  res_load;

    // Memory port controls.
    logic                  valid_we;
    logic [AW-1:0]         valid_waddr;
    logic                  upd_we;
    logic [AW-1:0]         map_waddr;
    logic [AW-1:0]         map_wdata;
    logic [AW-1:0]         pk_waddr;
    logic [AW-1:0]         pk_wdata;
    logic [DATA_WIDTH-1:0] pv_wdata;
    logic [AW-1:0]         dense_raddr;
    logic                  vals_re;
    logic [AW-1:0]         vals_raddr;

    assign in_range   = 32'(r_key) < 32'(CAPACITY);
    assign present    = in_range && valid_rd[0];
    assign full       = (r_count == CW'(CAPACITY));
    assign insert_ok  = i_cmd.eval && (r_kind == KIND_INSERT) && !present && in_range && !full;
    assign remove_ok  = i_cmd.eval && (r_kind == KIND_REMOVE) && present && (r_count != '0);
    assign need_fetch = (r_kind == KIND_LOOKUP) && present;
    assign res_load   = (i_cmd.eval && !need_fetch) || i_cmd.fetch;

    // Next count: append on insert, drop the last slot on remove.
    always_comb begin
        priority if (insert_ok) begin
            n_count = r_count + CW'(1);
        end else if (remove_ok) begin
            n_count = r_count - CW'(1);
        end else begin
            n_count = r_count;
        end
    end

    // Read the map entry of the key and, for reads and removes, one dense slot.
    // The dense slot is the requested position for a read, else the last entry.
    assign dense_raddr = (t_kind'(i_kind) == KIND_READ) ? AW'(i_position)
                                                         : AW'(r_count - CW'(1));
    assign vals_re     = i_cmd.accept || (i_cmd.eval && need_fetch);
    assign vals_raddr  = i_cmd.accept ? dense_raddr : map_rd;

    // Valid marks are written by the clearing pass, an insert or a remove.
    assign valid_we    = i_cmd.clr_step || insert_ok || remove_ok;
    assign valid_waddr = i_cmd.clr_step ? r_clr_addr : AW'(r_key);

    // Insert appends at count; remove moves the last entry into the hole.
    assign upd_we    = insert_ok || remove_ok;
    assign map_waddr = insert_ok ? AW'(r_key) : keys_rd;
    assign map_wdata = insert_ok ? AW'(r_count) : map_rd;
    assign pk_waddr  = insert_ok ? AW'(r_count) : map_rd;
    assign pk_wdata  = insert_ok ? AW'(r_key) : keys_rd;
    assign pv_wdata  = insert_ok ? r_value : vals_rd;

    sss_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_valid_ram (
        .i_clk   (i_clk),
        .i_we    (valid_we),
        .i_waddr (valid_waddr),
        .i_wdata (insert_ok),
        .i_re    (i_cmd.accept),
        .i_raddr (AW'(i_key)),
        .o_rdata (valid_rd)
    );

    sss_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (upd_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (AW'(i_key)),
        .o_rdata (map_rd)
    );

    sss_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_keys_ram (
        .i_clk   (i_clk),
        .i_we    (upd_we),
        .i_waddr (pk_waddr),
        .i_wdata (pk_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (dense_raddr),
        .o_rdata (keys_rd)
    );

    sss_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_vals_ram (
        .i_clk   (i_clk),
        .i_we    (upd_we),
        .i_waddr (pk_waddr),
        .i_wdata (pv_wdata),
        .i_re    (vals_re),
        .i_raddr (vals_raddr),
        .o_rdata (vals_rd)
    );

    // Result fields for the current item.
    always_comb begin
        n_res_status = ST_ABSENT;
        n_res_value  = '0;
        n_res_key    = '0;
        n_res_pos    = '0;
        unique case (r_kind)
            KIND_INSERT: begin
                if (present) begin
                    n_res_status = ST_PRESENT;
                    n_res_pos    = POS_W'(map_rd);
                end else if (insert_ok) begin
                    n_res_status = ST_OK;
                    n_res_pos    = POS_W'(r_count);
                end
            end
            KIND_REMOVE: begin
                if (remove_ok) begin
                    n_res_status = ST_OK;
                end
            end
            KIND_LOOKUP: begin
                n_res_key = r_key;
                if (present) begin
                    n_res_status = ST_OK;
                    n_res_value  = VAL_W'(vals_rd);
                    n_res_pos    = POS_W'(map_rd);
                end
            end
            KIND_READ: begin
                if (32'(r_pos) < 32'(r_count)) begin
                    n_res_status = ST_OK;
                    n_res_value  = VAL_W'(vals_rd);
                    n_res_key    = KEY_W'(keys_rd);
                    n_res_pos    = r_pos;
                end
            end
            default: begin
                n_res_status = ST_ABSENT;
            end
        endcase
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind  <= t_kind'(i_kind);
            r_key   <= i_key;
            r_value <= DATA_WIDTH'(i_value);
            r_pos   <= i_position;
        end
        if (res_load) begin
            r_res_status <= n_res_status;
            r_res_value  <= n_res_value;
            r_res_key    <= n_res_key;
            r_res_pos    <= n_res_pos;
            r_res_count  <= ECNT_W'(n_count);
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_value  <= r_res_value;
            r_out_key    <= r_res_key;
            r_out_pos    <= r_res_pos;
            r_out_count  <= r_res_count;
        end
    end

    // Count, clearing address and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.clr_last   = (r_clr_addr == AW'(CAPACITY - 1));
    assign o_sts.need_fetch = need_fetch;
    assign o_sts.out_busy   = r_out_valid && !i_ready;

    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_found_value    = r_out_value;
    assign o_found_key      = r_out_key;
    assign o_found_position = r_out_pos;
    assign o_entry_count    = r_out_count;

    // The count never passes the capacity.
    `SSS_ASSERT(a_count_cap, 32'(r_count) <= 32'(CAPACITY), "count beyond capacity")
    // A successful insert grows the store by exactly one entry.
    `SSS_ASSERT(a_insert_grow, insert_ok |=> (r_count == $past(r_count) + CW'(1)),
        "insert did not grow count")
    // Insert and remove never both take effect.
    `SSS_ASSERT(a_upd_excl, !(insert_ok && remove_ok), "insert and remove together")

endmodule
